[rtl/mwsm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Mecanum wheel speed mixer package
// Widths, types and constants shared by the mixer pipeline.
// ----------------------------------------------------------------------------
package mwsm_pkg;

   localparam int LIN_W      = 16;
   localparam int GAIN_W     = 16;
   localparam int SCALE_W    = 24;
   localparam int MAXV_W     = 10;
   localparam int CMD_W      = 11;
   localparam int PROD_W     = LIN_W + GAIN_W + 1;
   localparam int SUM_W      = PROD_W + 2;
   localparam int V_W        = SUM_W + SCALE_W;
   localparam int MAG_W      = 57;
   localparam int PP_W       = MAG_W + MAXV_W;
   localparam int QUO_W      = MAXV_W;
   localparam int FRAC_BITS  = 36;
   localparam int NUM_WHEELS = 4;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 24;

   localparam logic [MAG_W-1:0] THRESH_MAG = MAG_W'(64'd6871947674);

   localparam logic [CSR_ADDR_W-1:0] CSR_LINEAR_GAIN    = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_TURN_GAIN      = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_VELOCITY_SCALE = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_VELOCITY   = 2'd3;

   localparam logic [GAIN_W-1:0]  LINEAR_GAIN_RST    = 16'd8000;
   localparam logic [GAIN_W-1:0]  TURN_GAIN_RST      = 16'd1800;
   localparam logic [SCALE_W-1:0] VELOCITY_SCALE_RST = 24'd2732844;
   localparam logic [MAXV_W-1:0]  MAX_VELOCITY_RST   = 10'd265;

   localparam int WHEEL_FL = 0;
   localparam int WHEEL_FR = 1;
   localparam int WHEEL_RL = 2;
   localparam int WHEEL_RR = 3;

   typedef logic [MAG_W-1:0] mag_type;
   typedef mag_type [NUM_WHEELS-1:0] mag_vec_type;

   typedef struct packed {
      logic             valid;
      logic             scale;
      logic [MAG_W-1:0] max_mag;
   } ctl_type;

   typedef struct packed {
      logic              neg;
      logic [PP_W-1:0]   rem;
      logic [QUO_W-1:0]  quo;
      logic [MAXV_W-1:0] direct;
   } lane_type;

   typedef lane_type [NUM_WHEELS-1:0] lane_vec_type;

endpackage
`default_nettype wire

[rtl/mwsm_req_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Mixer command channel
// Valid/ready channel that carries one body velocity command.
// ----------------------------------------------------------------------------
interface mwsm_req_if;
   import mwsm_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [LIN_W-1:0] forward_vel;
   logic signed [LIN_W-1:0] lateral_vel;
   logic signed [LIN_W-1:0] turn_rate;

   modport source (output valid, forward_vel, lateral_vel, turn_rate, input ready);
   modport sink (input valid, forward_vel, lateral_vel, turn_rate, output ready);
endinterface

// ----------------------------------------------------------------------------
// Mixer result channel
// Valid/ready channel that carries four wheel speed commands.
// ----------------------------------------------------------------------------
interface mwsm_rsp_if;
   import mwsm_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [CMD_W-1:0] front_left_cmd;
   logic signed [CMD_W-1:0] front_right_cmd;
   logic signed [CMD_W-1:0] rear_left_cmd;
   logic signed [CMD_W-1:0] rear_right_cmd;

   modport source (output valid, front_left_cmd, front_right_cmd, rear_left_cmd,
                   rear_right_cmd, input ready);
   modport sink (input valid, front_left_cmd, front_right_cmd, rear_left_cmd,
                 rear_right_cmd, output ready);
endinterface
`default_nettype wire

[rtl/mwsm_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Mixer front end
// Gain products, wheel sums and velocity scaling in three register stages.
// ----------------------------------------------------------------------------
module mwsm_front (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             enable,
   input  wire logic                             in_valid,
   input  wire logic signed [mwsm_pkg::LIN_W-1:0]   forward_vel,
   input  wire logic signed [mwsm_pkg::LIN_W-1:0]   lateral_vel,
   input  wire logic signed [mwsm_pkg::LIN_W-1:0]   turn_rate,
   input  wire logic [mwsm_pkg::GAIN_W-1:0]         linear_gain,
   input  wire logic [mwsm_pkg::GAIN_W-1:0]         turn_gain,
   input  wire logic [mwsm_pkg::SCALE_W-1:0]        velocity_scale,
   output logic                                  out_valid,
   output logic [mwsm_pkg::NUM_WHEELS-1:0]          out_neg,
   output mwsm_pkg::mag_vec_type                     out_mag
);
   import mwsm_pkg::*;

   logic signed [GAIN_W:0]    lg_s;
   logic signed [GAIN_W:0]    tg_s;
   logic signed [SCALE_W:0]   vs_s;
   logic signed [PROD_W-1:0]  px_in, py_in, pw_in, px_ff, py_ff, pw_ff;
   logic signed [SUM_W-1:0]   sx, sy, sw;
   logic signed [SUM_W-1:0]   sum_in [NUM_WHEELS];
   logic signed [SUM_W-1:0]   sum_ff [NUM_WHEELS];
   logic signed [V_W-1:0]     v_w [NUM_WHEELS];
   logic [NUM_WHEELS-1:0]     neg_in, neg_ff;
   mag_vec_type               mag_in, mag_ff;
   logic                      v1_ff, v2_ff, v3_ff;

   always_comb begin
      lg_s  = $signed({1'b0, linear_gain});
      tg_s  = $signed({1'b0, turn_gain});
      vs_s  = $signed({1'b0, velocity_scale});
      px_in = forward_vel * lg_s;
      py_in = lateral_vel * lg_s;
      pw_in = turn_rate * tg_s;
      sx    = SUM_W'(px_ff);
      sy    = SUM_W'(py_ff);
      sw    = SUM_W'(pw_ff);
      sum_in[WHEEL_FL] = sx - sy - sw;
      sum_in[WHEEL_FR] = sx + sy + sw;
      sum_in[WHEEL_RL] = sx + sy - sw;
      sum_in[WHEEL_RR] = sx - sy + sw;
      for (int k = 0; k < NUM_WHEELS; k++) begin
         v_w[k]    = sum_ff[k] * vs_s;
         neg_in[k] = v_w[k][V_W-1];
         mag_in[k] = MAG_W'(neg_in[k] ? -v_w[k] : v_w[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (enable) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         px_ff  <= px_in;
         py_ff  <= py_in;
         pw_ff  <= pw_in;
         sum_ff <= sum_in;
         neg_ff <= neg_in;
         mag_ff <= mag_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_neg   = neg_ff;
   assign out_mag   = mag_ff;
endmodule
`default_nettype wire

[rtl/mwsm_desat.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Mixer desaturation setup
// Finds the largest wheel above threshold, decides on scaling and forms the
// dividends and the clamped direct results.
// ----------------------------------------------------------------------------
module mwsm_desat (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            enable,
   input  wire logic                            in_valid,
   input  wire logic [mwsm_pkg::NUM_WHEELS-1:0]    in_neg,
   input  wire mwsm_pkg::mag_vec_type               in_mag,
   input  wire logic [mwsm_pkg::MAXV_W-1:0]        max_velocity,
   output mwsm_pkg::ctl_type                        out_ctl,
   output mwsm_pkg::lane_vec_type                   out_lanes
);
   import mwsm_pkg::*;

   mag_type           qual [NUM_WHEELS];
   mag_type           max_a, max_b, max_all, lim_mag;
   logic [MAG_W-FRAC_BITS-1:0] whole;
   ctl_type           ctl_in, ctl_ff;
   lane_vec_type      lanes_in, lanes_ff;

   always_comb begin
      for (int k = 0; k < NUM_WHEELS; k++) begin
         qual[k] = (in_mag[k] >= THRESH_MAG) ? in_mag[k] : '0;
      end
      max_a   = (qual[0] > qual[1]) ? qual[0] : qual[1];
      max_b   = (qual[2] > qual[3]) ? qual[2] : qual[3];
      max_all = (max_a > max_b) ? max_a : max_b;
      lim_mag = MAG_W'(max_velocity) << FRAC_BITS;
      ctl_in.valid   = in_valid;
      ctl_in.scale   = max_all > lim_mag;
      ctl_in.max_mag = max_all;
      for (int k = 0; k < NUM_WHEELS; k++) begin
         whole = in_mag[k][MAG_W-1:FRAC_BITS];
         lanes_in[k].neg    = in_neg[k];
         lanes_in[k].rem    = PP_W'(in_mag[k]) * PP_W'(max_velocity);
         lanes_in[k].quo    = '0;
         lanes_in[k].direct = (whole > (MAG_W-FRAC_BITS)'(max_velocity)) ?
                              max_velocity : whole[MAXV_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (enable) begin
         ctl_ff.valid <= ctl_in.valid;
      end
      if (enable) begin
         ctl_ff.scale   <= ctl_in.scale;
         ctl_ff.max_mag <= ctl_in.max_mag;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         lanes_ff <= lanes_in;
      end
   end

   assign out_ctl   = ctl_ff;
   assign out_lanes = lanes_ff;
endmodule
`default_nettype wire

[rtl/mwsm_div_stage.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Mixer divider stage
// One restoring division step for all four wheels, one quotient bit.
// ----------------------------------------------------------------------------
module mwsm_div_stage #(
   parameter int BIT = 0
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 enable,
   input  wire mwsm_pkg::ctl_type      in_ctl,
   input  wire mwsm_pkg::lane_vec_type in_lanes,
   output mwsm_pkg::ctl_type           out_ctl,
   output mwsm_pkg::lane_vec_type      out_lanes
);
   import mwsm_pkg::*;

   logic [PP_W-1:0] divisor;
   lane_vec_type    lanes_in, lanes_ff;
   ctl_type         ctl_ff;

   always_comb begin
      divisor  = PP_W'(in_ctl.max_mag) << BIT;
      lanes_in = in_lanes;
      for (int k = 0; k < NUM_WHEELS; k++) begin
         if (in_lanes[k].rem >= divisor) begin
            lanes_in[k].rem      = in_lanes[k].rem - divisor;
            lanes_in[k].quo[BIT] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (enable) begin
         ctl_ff.valid <= in_ctl.valid;
      end
      if (enable) begin
         ctl_ff.scale   <= in_ctl.scale;
         ctl_ff.max_mag <= in_ctl.max_mag;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         lanes_ff <= lanes_in;
      end
   end

   assign out_ctl   = ctl_ff;
   assign out_lanes = lanes_ff;
endmodule
`default_nettype wire

[rtl/mecanum_wheel_speed_mixer.sv]
`default_nettype none
// An accepted command passes the front end, the desaturation setup, the divider stages and the result register.
// Throughput: one command per cycle; the whole pipeline holds while the result
// register is full and not taken.
// The ten divider stages, one quotient bit each, set the depth.
// Reset clears all valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
// Mecanum wheel speed mixer
// Body velocity command to four wheel speed commands with desaturation.
// ----------------------------------------------------------------------------
module mecanum_wheel_speed_mixer (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_write_enable,
   input  wire logic [mwsm_pkg::CSR_ADDR_W-1:0]    csr_index,
   input  wire logic [mwsm_pkg::CSR_DATA_W-1:0]    csr_write_data,
   mwsm_req_if.sink                             req,
   mwsm_rsp_if.source                           rsp
);
   import mwsm_pkg::*;

   logic [GAIN_W-1:0]     linear_gain_ff, turn_gain_ff;
   logic [SCALE_W-1:0]    velocity_scale_ff;
   logic [MAXV_W-1:0]     max_velocity_ff;
   logic                  advance;
   logic                  f_valid;
   logic [NUM_WHEELS-1:0] f_neg;
   mag_vec_type           f_mag;
   ctl_type               ctl_chain [QUO_W+1];
   lane_vec_type          lane_chain [QUO_W+1];
   logic [MAXV_W-1:0]     r_sel [NUM_WHEELS];
   logic signed [CMD_W-1:0] cmd_in [NUM_WHEELS];
   logic signed [CMD_W-1:0] cmd_ff [NUM_WHEELS];
   logic                  rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         linear_gain_ff    <= LINEAR_GAIN_RST;
         turn_gain_ff      <= TURN_GAIN_RST;
         velocity_scale_ff <= VELOCITY_SCALE_RST;
         max_velocity_ff   <= MAX_VELOCITY_RST;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_LINEAR_GAIN:    linear_gain_ff    <= csr_write_data[GAIN_W-1:0];
            CSR_TURN_GAIN:      turn_gain_ff      <= csr_write_data[GAIN_W-1:0];
            CSR_VELOCITY_SCALE: velocity_scale_ff <= csr_write_data[SCALE_W-1:0];
            CSR_MAX_VELOCITY:   max_velocity_ff   <= csr_write_data[MAXV_W-1:0];
            default: ;
         endcase
      end
   end

   assign advance   = !rsp_valid_ff || rsp.ready;
   assign req.ready = advance;

   mwsm_front u_front (
      .clock          (clock),
      .reset          (reset),
      .enable         (advance),
      .in_valid       (req.valid),
      .forward_vel    (req.forward_vel),
      .lateral_vel    (req.lateral_vel),
      .turn_rate      (req.turn_rate),
      .linear_gain    (linear_gain_ff),
      .turn_gain      (turn_gain_ff),
      .velocity_scale (velocity_scale_ff),
      .out_valid      (f_valid),
      .out_neg        (f_neg),
      .out_mag        (f_mag)
   );

   mwsm_desat u_desat (
      .clock        (clock),
      .reset        (reset),
      .enable       (advance),
      .in_valid     (f_valid),
      .in_neg       (f_neg),
      .in_mag       (f_mag),
      .max_velocity (max_velocity_ff),
      .out_ctl      (ctl_chain[0]),
      .out_lanes    (lane_chain[0])
   );

   for (genvar g = 0; g < QUO_W; g++) begin : g_div
      mwsm_div_stage #(.BIT(QUO_W - 1 - g)) u_stage (
         .clock     (clock),
         .reset     (reset),
         .enable    (advance),
         .in_ctl    (ctl_chain[g]),
         .in_lanes  (lane_chain[g]),
         .out_ctl   (ctl_chain[g+1]),
         .out_lanes (lane_chain[g+1])
      );
   end

   always_comb begin
      for (int k = 0; k < NUM_WHEELS; k++) begin
         r_sel[k]  = ctl_chain[QUO_W].scale ? lane_chain[QUO_W][k].quo :
                     lane_chain[QUO_W][k].direct;
         cmd_in[k] = lane_chain[QUO_W][k].neg ? -$signed({1'b0, r_sel[k]}) :
                     $signed({1'b0, r_sel[k]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= ctl_chain[QUO_W].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cmd_ff <= cmd_in;
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.front_left_cmd  = cmd_ff[WHEEL_FL];
   assign rsp.front_right_cmd = cmd_ff[WHEEL_FR];
   assign rsp.rear_left_cmd   = cmd_ff[WHEEL_RL];
   assign rsp.rear_right_cmd  = cmd_ff[WHEEL_RR];
endmodule
`default_nettype wire
